FILE: hdl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// shared types and constants of the splat pixel compositor
// ----------------------------------------------------------------------------
package spc_pkg;

    // stream payload layout, slave side (tdata, lowest bit first)
    localparam int IN_DATA_W   = 128;
    localparam int IN_IDX_LSB  = 0;
    localparam int IN_CX_LSB   = 4;
    localparam int IN_CY_LSB   = 20;
    localparam int IN_SIG_LSB  = 36;
    localparam int IN_OP_LSB   = 52;
    localparam int IN_CR_LSB   = 68;
    localparam int IN_CG_LSB   = 81;
    localparam int IN_CB_LSB   = 94;
    localparam int IN_PX_LSB   = 107;
    localparam int IN_PY_LSB   = 115;

    // stream payload layout, master side
    localparam int OUT_DATA_W  = 40;

    localparam int POS_W   = 16;
    localparam int COL_W   = 13;
    localparam int OPA_W   = 16;
    localparam int FO_W    = 24;
    localparam int PIX_W   = 8;
    localparam int W_W     = 31;
    localparam int PROD_W  = 57;

    localparam int MAX_IMAGE_DIM = 256;
    localparam int PIX_MAX       = MAX_IMAGE_DIM - 1;

    localparam logic [15:0] T_ONE        = 16'h8000;
    localparam logic [15:0] OPA_MAX      = 16'h8000;
    localparam logic [12:0] COL_MAX      = 13'h1000;
    localparam logic [15:0] CUTOFF_RESET = 16'd33;
    localparam logic [23:0] FO_MAX       = 24'hFF_FFFF;

    // falloff divider: 36 quotient bits of (2^35 + s2/2) / s2
    localparam int DIV_STEPS = 36;
    localparam int DIV_NUM_W = 36;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_SHADE = 1'b1
    } t_func;

    typedef enum logic {
        REG_ACTIVE_COUNT = 1'b0,
        REG_CUTOFF       = 1'b1
    } t_reg_sel;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PREP  = 4'b0010,
        S_DIV   = 4'b0100,
        S_WRITE = 4'b1000
    } t_div_state;

endpackage

FILE: hdl/gaussian_splat_pixel_compositor_top.sv
// ----------------------------------------------------------------------------
// gaussian_splat_pixel_compositor_top
// front-to-back alpha compositing of isotropic 2d gaussians for one pixel
// ----------------------------------------------------------------------------
//  channel    dir  transaction
//  s_axis     in   tuser = func, tdata = load entry or pixel coordinates
//  m_axis     out  tdata = composited rgb, tuser = stopped_early
//  apb        in   active_count at 0x0, transmittance_cutoff at 0x4
//
//  a shade transaction enters every cycle while no stall or load holds the input;
//  its result passes 6 lane stages, one cell per gaussian, one tail, output reg
//  a load transaction waits for an empty pipeline, then the falloff divider
//  runs one quotient bit a cycle: no input is taken until it writes the entry
//  reset (synchronous, active low) clears valid bits, active_count and the fsm
//  and sets the cutoff to its default; table entries hold nothing until loaded
//  a stall on m_axis freezes the whole pipeline; the output register holds
// ----------------------------------------------------------------------------
module gaussian_splat_pixel_compositor_top
    import spc_pkg::*;
#(
    parameter int MAX_GAUSSIANS  = 16,
    parameter int EXP_TABLE_SIZE = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // apb configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // entry_index, center_x, center_y, sigma, opacity, color_red, color_green,
    // color_blue, pixel_x, pixel_y, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func
    input  logic                  s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_red, out_green, out_blue, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // stopped_early
    output logic                  m_axis_tuser
);

    localparam int NG      = MAX_GAUSSIANS;
    localparam int FRONT   = 6;
    localparam int LW      = $clog2(EXP_TABLE_SIZE);
    localparam int SCW     = 40 + LW + 1;
    localparam int AW      = 44 + $clog2(NG + 1);
    localparam logic [35:0] NUM_BASE = 36'h8_0000_0000;

    // exp(-16 i / size) in q1.15, built with q30 taylor series
    function automatic logic [EXP_TABLE_SIZE*16-1:0] build_exp_lut();
        logic [63:0] tq;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] r;
        logic [63:0] e;
        logic [EXP_TABLE_SIZE*16-1:0] lut;
        tq   = 64'h4_0000_0000 / EXP_TABLE_SIZE;
        term = 64'd1 << 30;
        sum  = 64'sd1 <<< 30;
        for (int n = 1; n <= 24; n++) begin
            term = ((term * tq) >> 30) / 64'(n);
            if ((n % 2) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        r   = 64'(sum);
        e   = 64'd1 << 30;
        lut = '0;
        lut[15:0] = T_ONE;
        for (int i = 1; i < EXP_TABLE_SIZE; i++) begin
            e = (e * r + (64'd1 << 29)) >> 30;
            lut[i*16 +: 16] = 16'((e + (64'd1 << 14)) >> 15);
        end
        return lut;
    endfunction

    localparam logic [EXP_TABLE_SIZE*16-1:0] EXP_LUT = build_exp_lut();

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [4:0]  r_active_count;
    logic [15:0] r_cutoff;
    t_reg_sel    cfg_sel;

    assign cfg_sel = t_reg_sel'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_count <= '0;
            r_cutoff       <= CUTOFF_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (cfg_sel)
                REG_ACTIVE_COUNT: r_active_count <= pwdata[4:0];
                REG_CUTOFF:       r_cutoff       <= pwdata[15:0];
                default:          r_cutoff       <= r_cutoff;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_ACTIVE_COUNT: prdata = {27'b0, r_active_count};
            REG_CUTOFF:       prdata = {16'b0, r_cutoff};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // input field unpacking
    // ------------------------------------------------------------------
    t_func             in_func;
    logic [3:0]        in_idx;
    logic [POS_W-1:0]  in_cx, in_cy, in_sigma;
    logic [OPA_W-1:0]  in_op, in_op_sat;
    logic [COL_W-1:0]  in_col [3];
    logic [COL_W-1:0]  in_col_sat [3];
    logic [PIX_W-1:0]  in_px, in_py, px_c, py_c;
    logic [POS_W-1:0]  samp_x, samp_y;

    assign in_func   = t_func'(s_axis_tuser);
    assign in_idx    = s_axis_tdata[IN_IDX_LSB +: 4];
    assign in_cx     = s_axis_tdata[IN_CX_LSB +: POS_W];
    assign in_cy     = s_axis_tdata[IN_CY_LSB +: POS_W];
    assign in_sigma  = s_axis_tdata[IN_SIG_LSB +: POS_W];
    assign in_op     = s_axis_tdata[IN_OP_LSB +: OPA_W];
    assign in_col[0] = s_axis_tdata[IN_CR_LSB +: COL_W];
    assign in_col[1] = s_axis_tdata[IN_CG_LSB +: COL_W];
    assign in_col[2] = s_axis_tdata[IN_CB_LSB +: COL_W];
    assign in_px     = s_axis_tdata[IN_PX_LSB +: PIX_W];
    assign in_py     = s_axis_tdata[IN_PY_LSB +: PIX_W];

    // saturate on load, zero sigma stores zero opacity
    assign in_op_sat = (in_sigma == '0) ? '0 : ((in_op > OPA_MAX) ? OPA_MAX : in_op);
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            in_col_sat[c] = (in_col[c] > COL_MAX) ? COL_MAX : in_col[c];
        end
    end

    // pixel center sample in q8.8
    assign px_c   = (int'(in_px) > PIX_MAX) ? PIX_W'(PIX_MAX) : in_px;
    assign py_c   = (int'(in_py) > PIX_MAX) ? PIX_W'(PIX_MAX) : in_py;
    assign samp_x = {px_c, 8'h80};
    assign samp_y = {py_c, 8'h80};

    // ------------------------------------------------------------------
    // handshake and pipeline enable
    // ------------------------------------------------------------------
    t_div_state r_state;
    logic       en;
    logic       pipe_empty;
    logic       in_acc;
    logic       shade_acc;
    logic       ld_acc;
    logic       ld_go;
    logic       r_ovalid;
    logic [FRONT-1:0] r_fvalid;
    logic [NG-1:0]    r_cvalid;
    logic       r_tvalid;

    assign en         = !r_ovalid || m_axis_tready;
    assign pipe_empty = (r_fvalid == '0) && (r_cvalid == '0) && !r_tvalid;
    // shades follow each other freely; a load needs every shade ahead of it gone
    assign s_axis_tready = (r_state == S_IDLE) &&
                           ((in_func == FUNC_SHADE) ? en : pipe_empty);
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign shade_acc = in_acc && (in_func == FUNC_SHADE);
    assign ld_acc    = in_acc && (in_func == FUNC_LOAD);
    // loads past the table end are dropped
    assign ld_go     = ld_acc && (int'(in_idx) < NG);

    // ------------------------------------------------------------------
    // gaussian table
    // ------------------------------------------------------------------
    logic [POS_W-1:0] r_tab_cx [NG];
    logic [POS_W-1:0] r_tab_cy [NG];
    logic [FO_W-1:0]  r_tab_fo [NG];
    logic [OPA_W-1:0] r_tab_op [NG];
    logic [COL_W-1:0] r_tab_col [NG][3];

    // falloff divider
    logic [31:0]          r_d;
    logic                 r_ld_zero;
    logic [3:0]           r_ld_idx;
    logic [DIV_NUM_W-1:0] r_num;
    logic [31:0]          r_rem;
    logic [5:0]           r_cnt;
    logic [32:0]          div_trial;
    logic                 div_ge;
    logic [FO_W-1:0]      fo_new;

    assign div_trial = {r_rem, r_num[DIV_NUM_W-1]};
    assign div_ge    = div_trial >= {1'b0, r_d};
    assign fo_new    = r_ld_zero ? '0 :
                       ((r_num > DIV_NUM_W'(FO_MAX)) ? FO_MAX : r_num[FO_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE:  if (ld_go) r_state <= S_PREP;
                S_PREP:  r_state <= S_DIV;
                S_DIV:   if (r_cnt == 6'(DIV_STEPS - 1)) r_state <= S_WRITE;
                S_WRITE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_go) begin
            r_d       <= 32'(in_sigma) * 32'(in_sigma);
            r_ld_zero <= (in_sigma == '0);
            r_ld_idx  <= in_idx;
        end
        if (r_state == S_PREP) begin
            // round(2^35 / s2): numerator carries half the divisor
            r_num <= NUM_BASE + DIV_NUM_W'(r_d >> 1);
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_state == S_DIV) begin
            if (div_ge) begin
                r_rem <= 32'(div_trial - {1'b0, r_d});
            end else begin
                r_rem <= div_trial[31:0];
            end
            r_num <= {r_num[DIV_NUM_W-2:0], div_ge};
            r_cnt <= r_cnt + 6'd1;
        end
    end

    for (genvar j = 0; j < NG; j++) begin : g_entry
        always_ff @(posedge i_clk) begin
            if (ld_go && (int'(in_idx) == j)) begin
                r_tab_cx[j] <= in_cx;
                r_tab_cy[j] <= in_cy;
                r_tab_op[j] <= in_op_sat;
                for (int c = 0; c < 3; c++) begin
                    r_tab_col[j][c] <= in_col_sat[c];
                end
            end
            if ((r_state == S_WRITE) && (int'(r_ld_idx) == j)) begin
                r_tab_fo[j] <= fo_new;
            end
        end
    end

    // ------------------------------------------------------------------
    // lane stages: alpha of every gaussian, independent of transmittance
    // ------------------------------------------------------------------
    logic [15:0]       r_adx  [NG];
    logic [15:0]       r_ady  [NG];
    logic [31:0]       r_dx2  [NG];
    logic [31:0]       r_dy2  [NG];
    logic [32:0]       r_r2   [NG];
    logic [PROD_W-1:0] r_prod [NG];
    logic [15:0]       r_g    [NG];
    logic [15:0]       r_alpha[NG];

    for (genvar j = 0; j < NG; j++) begin : g_lane
        logic [SCW-1:0]   sc;
        logic [LW-1:0]    lut_idx;
        logic [15:0]      g_val;
        logic [30:0]      a_prod;
        logic [15:0]      a_rnd;

        assign sc      = SCW'(r_prod[j][39:0]) * SCW'(EXP_TABLE_SIZE);
        assign lut_idx = sc[40 +: LW];
        // arguments of 16 or more fall off the table
        assign g_val   = (r_prod[j][PROD_W-1:40] != '0) ? '0 :
                         EXP_LUT[int'(lut_idx)*16 +: 16];
        assign a_prod  = 31'(r_tab_op[j]) * 31'(r_g[j]);
        assign a_rnd   = 16'((a_prod + 31'(1 << 14)) >> 15);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_adx[j]   <= (samp_x >= r_tab_cx[j]) ? samp_x - r_tab_cx[j]
                                                      : r_tab_cx[j] - samp_x;
                r_ady[j]   <= (samp_y >= r_tab_cy[j]) ? samp_y - r_tab_cy[j]
                                                      : r_tab_cy[j] - samp_y;
                r_dx2[j]   <= 32'(r_adx[j]) * 32'(r_adx[j]);
                r_dy2[j]   <= 32'(r_ady[j]) * 32'(r_ady[j]);
                r_r2[j]    <= 33'(r_dx2[j]) + 33'(r_dy2[j]);
                r_prod[j]  <= PROD_W'(r_r2[j]) * PROD_W'(r_tab_fo[j]);
                r_g[j]     <= g_val;
                r_alpha[j] <= (a_rnd > OPA_MAX) ? OPA_MAX : a_rnd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvalid <= '0;
        end else if (en) begin
            r_fvalid <= {r_fvalid[FRONT-2:0], shade_acc};
        end
    end

    // ------------------------------------------------------------------
    // cell chain: one stage per gaussian, transmittance walks front to back
    // each cell also folds the previous cell's weight into the color sums
    // ------------------------------------------------------------------
    logic [15:0]    r_c_t     [NG];
    logic           r_c_live  [NG];
    logic           r_c_stop  [NG];
    logic [W_W-1:0] r_c_w     [NG];
    logic [AW-1:0]  r_c_acc   [NG][3];
    logic [15:0]    r_c_alpha [NG][NG];

    for (genvar k = 0; k < NG; k++) begin : g_cell
        logic [15:0]    in_t;
        logic           in_live;
        logic           in_stop;
        logic [AW-1:0]  cell_acc [3];
        logic [15:0]    cell_alpha [NG];
        logic [15:0]    alpha;
        logic           act;
        logic           last_ok;
        logic [30:0]    t_prod;
        logic [15:0]    t_rnd;
        logic           hit;

        if (k == 0) begin : g_head
            always_comb begin
                in_t       = T_ONE;
                in_live    = 1'b1;
                in_stop    = 1'b0;
                cell_alpha = r_alpha;
                for (int c = 0; c < 3; c++) begin
                    cell_acc[c] = '0;
                end
            end
        end else begin : g_body
            always_comb begin
                in_t       = r_c_t[k-1];
                in_live    = r_c_live[k-1];
                in_stop    = r_c_stop[k-1];
                cell_alpha = r_c_alpha[k-1];
                for (int c = 0; c < 3; c++) begin
                    cell_acc[c] = r_c_acc[k-1][c] +
                                  AW'(44'(r_tab_col[k-1][c]) * 44'(r_c_w[k-1]));
                end
            end
        end

        // stopping here counts as early only if a later gaussian was due
        if (k + 1 < NG) begin : g_more
            assign last_ok = int'(r_active_count) > k + 1;
        end else begin : g_last
            assign last_ok = 1'b0;
        end

        assign alpha  = cell_alpha[k];
        assign act    = in_live && (int'(r_active_count) > k);
        assign t_prod = 31'(in_t) * 31'(T_ONE - alpha);
        assign t_rnd  = 16'((t_prod + 31'(1 << 14)) >> 15);
        assign hit    = act && (t_rnd < r_cutoff);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_c_t[k]     <= act ? t_rnd : in_t;
                r_c_w[k]     <= act ? W_W'(31'(alpha) * 31'(in_t)) : '0;
                r_c_live[k]  <= in_live && !hit;
                r_c_stop[k]  <= in_stop || (hit && last_ok);
                r_c_alpha[k] <= cell_alpha;
                for (int c = 0; c < 3; c++) begin
                    r_c_acc[k][c] <= cell_acc[c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
        end else if (en) begin
            if (NG > 1) begin
                r_cvalid <= NG'({r_cvalid, r_fvalid[FRONT-1]});
            end else begin
                r_cvalid <= NG'(r_fvalid[FRONT-1]);
            end
        end
    end

    // ------------------------------------------------------------------
    // tail: last weight, then rounding and saturation into the output reg
    // ------------------------------------------------------------------
    logic [AW-1:0]    r_tail_acc [3];
    logic             r_tail_stop;
    logic [COL_W-1:0] r_out_col [3];
    logic             r_out_stop;
    logic [AW:0]      o_rnd [3];
    logic [AW:0]      o_q   [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r_tail_acc[c] <= r_c_acc[NG-1][c] +
                                 AW'(44'(r_tab_col[NG-1][c]) * 44'(r_c_w[NG-1]));
            end
            r_tail_stop <= r_c_stop[NG-1];
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            o_rnd[c] = (AW+1)'(r_tail_acc[c]) + (AW+1)'(1 << 29);
            o_q[c]   = o_rnd[c] >> 30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_tvalid <= r_cvalid[NG-1];
            r_ovalid <= r_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_tvalid) begin
            for (int c = 0; c < 3; c++) begin
                r_out_col[c] <= (o_q[c] > (AW+1)'(COL_MAX)) ? COL_MAX
                                                             : o_q[c][COL_W-1:0];
            end
            r_out_stop <= r_tail_stop;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_out_col[2], r_out_col[1], r_out_col[0]};
    assign m_axis_tuser  = r_out_stop;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_shade_while_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !shade_acc)
        else $error("shade taken while falloff divider busy");

    a_load_on_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_acc |-> pipe_empty)
        else $error("load taken with shades in flight");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_fvalid) && $stable(r_cvalid) && $stable(r_tvalid)))
        else $error("pipeline moved during stall");

    a_tail_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_tvalid) |=> r_ovalid)
        else $error("finished pixel lost before output register");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < 6'(DIV_STEPS)))
        else $error("divider step count overrun");

endmodule
